### design/ltpid_pkg.sv
// Shared types and constants of the light tracker PID controller.
// No dependencies; every design file but ltpid_if refers to it by scoped names.
package ltpid_pkg;

    // Tracker states, also the code shown in active_state.
    localparam logic [2:0] ST_OFF    = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_SLEEP  = 3'd3;
    localparam logic [2:0] ST_TRACK  = 3'd4;
    localparam logic [2:0] ST_HOLD   = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_LIGHT_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_ALIGN_DEADBAND  = 3'd1;
    localparam logic [2:0] REG_SEARCH_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_GAIN_P          = 3'd3;
    localparam logic [2:0] REG_GAIN_I          = 3'd4;
    localparam logic [2:0] REG_GAIN_D          = 3'd5;
    localparam logic [2:0] REG_PULSE_MIN       = 3'd6;
    localparam logic [2:0] REG_PULSE_MAX       = 3'd7;

    localparam int CFG_DATA_W = 16;

    localparam logic [11:0] CENTER_US   = 12'd1500;
    localparam logic [16:0] TIMER_MAX   = 17'd131071;
    localparam int          INTEG_LIMIT = 2048000;
    localparam logic [9:0]  MS_PER_S    = 10'd1000;

    // floor(n * 1024 / 1000) equals (n * INTEG_RECIP) >> INTEG_RECIP_SHIFT for n < 2^19.
    localparam logic [26:0] INTEG_RECIP       = 27'd68719477;
    localparam int          INTEG_RECIP_SHIFT = 26;

    // Two quotient bits per cycle over a 32-bit dividend.
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic [9:0]  light_threshold;
        logic [10:0] align_deadband;
        logic [15:0] search_timeout_ms;
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [11:0] pulse_min_us;
        logic [11:0] pulse_max_us;
    } cfg_t;

    // One classified tick as it travels from the front end to the back end.
    typedef struct packed {
        logic signed [11:0] ex;
        logic signed [11:0] ey;
        logic [7:0]         dt;
        logic               light;
        logic               aligned;
        logic               power;
    } tick_t;

endpackage

### design/ltpid_if.sv
// Valid/ready channel interfaces for sample ticks and result items.
// Depends on nothing.
interface ltpid_sample_if;
    logic       valid;
    logic       ready;
    logic [9:0] top_left;
    logic [9:0] top_right;
    logic [9:0] low_left;
    logic [9:0] low_right;
    logic [7:0] elapsed_ms;
    logic       power_on;

    modport source (output valid, top_left, top_right, low_left, low_right,
                    elapsed_ms, power_on, input ready);
    modport sink   (input valid, top_left, top_right, low_left, low_right,
                    elapsed_ms, power_on, output ready);
endinterface

interface ltpid_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  active_state;
    logic [11:0] pulse_x_us;
    logic [11:0] pulse_y_us;
    logic        pulse_update;

    modport source (output valid, active_state, pulse_x_us, pulse_y_us, pulse_update,
                    input ready);
    modport sink   (input valid, active_state, pulse_x_us, pulse_y_us, pulse_update,
                    output ready);
endinterface

### design/ltpid_front.sv
// Front end: forms the axis errors, the light and alignment flags and dt.
// Depends on ltpid_pkg and ltpid_sample_if.
module ltpid_front (
    ltpid_sample_if.sink    sample,
    input  ltpid_pkg::cfg_t cfg,
    input  logic            push_ready,
    output logic            push_valid,
    output ltpid_pkg::tick_t push_tick
);
    logic [10:0] sum_right, sum_left, sum_top, sum_low;
    logic [10:0] abs_x, abs_y;

    always_comb
    begin
        sum_right = 11'(sample.top_right) + 11'(sample.low_right);
        sum_left  = 11'(sample.top_left) + 11'(sample.low_left);
        sum_top   = 11'(sample.top_left) + 11'(sample.top_right);
        sum_low   = 11'(sample.low_left) + 11'(sample.low_right);

        push_tick.ex = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
        push_tick.ey = $signed({1'b0, sum_top}) - $signed({1'b0, sum_low});

        abs_x = push_tick.ex[11] ? 11'(-push_tick.ex) : push_tick.ex[10:0];
        abs_y = push_tick.ey[11] ? 11'(-push_tick.ey) : push_tick.ey[10:0];

        push_tick.light = (sample.top_left > cfg.light_threshold)
                       || (sample.top_right > cfg.light_threshold)
                       || (sample.low_left > cfg.light_threshold)
                       || (sample.low_right > cfg.light_threshold);
        push_tick.aligned = (abs_x <= cfg.align_deadband) && (abs_y <= cfg.align_deadband);
        push_tick.dt      = (sample.elapsed_ms == 8'd0) ? 8'd1 : sample.elapsed_ms;
        push_tick.power   = sample.power_on;
    end

    assign push_valid   = sample.valid;
    assign sample.ready = push_ready;

endmodule

### design/ltpid_queue.sv
// Short FIFO of classified ticks between the front end and the back end.
// Depends on ltpid_pkg.
module ltpid_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  ltpid_pkg::tick_t push_tick,
    output logic             pop_valid,
    input  logic             pop,
    output ltpid_pkg::tick_t pop_tick
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ltpid_pkg::tick_t entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tick   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_tick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/ltpid_div.sv
// Iterative signed divider, quotient truncated toward zero, two bits per cycle.
// Depends on ltpid_pkg.
module ltpid_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic [9:0]         divisor,
    output logic               done,
    output logic signed [31:0] quotient
);
    localparam int CNT_W = $clog2(ltpid_pkg::DIV_STEPS + 1);

    logic [31:0]      quo_reg;
    logic [9:0]       rem_reg;
    logic [9:0]       dsr_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [10:0] r_a, r_b;
    logic        ge_a, ge_b;
    logic [9:0]  rem_a, rem_b;

    always_comb
    begin
        r_a   = {rem_reg, quo_reg[31]};
        ge_a  = (r_a >= {1'b0, dsr_reg});
        rem_a = ge_a ? 10'(r_a - {1'b0, dsr_reg}) : r_a[9:0];
        r_b   = {rem_a, quo_reg[30]};
        ge_b  = (r_b >= {1'b0, dsr_reg});
        rem_b = ge_b ? 10'(r_b - {1'b0, dsr_reg}) : r_b[9:0];
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else if (start)
        begin
            neg_reg  <= dividend[31];
            quo_reg  <= dividend[31] ? 32'(-dividend) : dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
            cnt_reg  <= CNT_W'(ltpid_pkg::DIV_STEPS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg  <= {quo_reg[29:0], ge_a, ge_b};
            rem_reg  <= rem_b;
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

### design/ltpid_back.sv
// Back end: tracker state machine, PID sequencer and result register.
// Depends on ltpid_pkg, ltpid_result_if and ltpid_div.
module ltpid_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ltpid_pkg::cfg_t  cfg,
    input  logic             pop_valid,
    input  ltpid_pkg::tick_t pop_tick,
    output logic             pop,
    ltpid_result_if.source   result
);
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MUL  = 3'd1;
    localparam logic [2:0] PH_DST  = 3'd2;
    localparam logic [2:0] PH_DIV  = 3'd3;
    localparam logic [2:0] PH_ADD  = 3'd4;
    localparam logic [2:0] PH_POS  = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;
    localparam logic [2:0] PH_RCP  = 3'd7;

    // Sequencer steps: 0..3 integral and derivative updates, 4..9 PID terms.
    localparam logic [3:0] SP_INTEG_X = 4'd0;
    localparam logic [3:0] SP_INTEG_Y = 4'd1;
    localparam logic [3:0] SP_DERIV_X = 4'd2;
    localparam logic [3:0] SP_DERIV_Y = 4'd3;
    localparam logic [3:0] SP_P_X     = 4'd4;
    localparam logic [3:0] SP_D_X     = 4'd5;
    localparam logic [3:0] SP_I_X     = 4'd6;
    localparam logic [3:0] SP_P_Y     = 4'd7;
    localparam logic [3:0] SP_D_Y     = 4'd8;
    localparam logic [3:0] SP_I_Y     = 4'd9;

    logic [2:0]  phase_reg;
    logic [3:0]  step_reg;
    logic [2:0]  pend_reg, act_reg;
    logic [16:0] timer_reg;
    logic        first_reg;
    logic signed [11:0] prev_ex_reg, prev_ey_reg, pex_reg, pey_reg;
    logic signed [22:0] integ_x_reg, integ_y_reg;
    logic signed [23:0] deriv_x_reg, deriv_y_reg;
    logic [11:0] pos_x_reg, pos_y_reg;
    logic        upd_reg;
    ltpid_pkg::tick_t cur_reg;
    logic signed [41:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic [19:0] rcp_reg;
    logic        rcp_neg_reg;

    logic        out_valid_reg;
    logic [2:0]  out_state_reg;
    logic [11:0] out_x_reg, out_y_reg;
    logic        out_upd_reg;

    logic [17:0] timer_sum;
    logic [16:0] timer_next;
    logic        first_next;
    logic        track_entry;
    logic [2:0]  pend_next;

    logic signed [17:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [41:0] mul_p;
    logic signed [51:0] term;

    logic               div_start, div_done;
    logic signed [31:0] div_dividend, div_quot;
    logic [9:0]         div_divisor;
    logic [19:0]        rcp_mag;
    logic [45:0]        rcp_prod;
    logic signed [20:0] rcp_quot;
    logic signed [24:0] integ_sum;
    logic signed [22:0] integ_clamped;
    logic signed [22:0] integ_sel;

    logic signed [29:0] pid_q;
    logic signed [30:0] pulse_raw, pulse_lo, pulse_hi;
    logic [11:0]        pulse_val;

    logic out_free;

    assign out_free = !out_valid_reg || result.ready;
    assign pop      = (phase_reg == PH_IDLE) && pop_valid;

    // Bookkeeping done when a tick is taken from the queue.
    always_comb
    begin
        timer_sum   = 18'(timer_reg) + 18'(pop_tick.dt);
        if ((pend_reg == ltpid_pkg::ST_SEARCH) && (act_reg != ltpid_pkg::ST_SEARCH))
        begin
            timer_next = '0;
        end
        else
        begin
            timer_next = (timer_sum > 18'(ltpid_pkg::TIMER_MAX)) ? ltpid_pkg::TIMER_MAX
                                                                 : timer_sum[16:0];
        end
        track_entry = (pend_reg == ltpid_pkg::ST_TRACK) && (act_reg != ltpid_pkg::ST_TRACK);
        first_next  = track_entry ? 1'b1 : first_reg;

        case (pend_reg)
            ltpid_pkg::ST_OFF:    pend_next = ltpid_pkg::ST_INIT;
            ltpid_pkg::ST_INIT:   pend_next = ltpid_pkg::ST_SEARCH;
            ltpid_pkg::ST_SEARCH:
            begin
                if (pop_tick.light)
                begin
                    pend_next = ltpid_pkg::ST_TRACK;
                end
                else if (timer_next > 17'(cfg.search_timeout_ms))
                begin
                    pend_next = ltpid_pkg::ST_SLEEP;
                end
                else
                begin
                    pend_next = ltpid_pkg::ST_SEARCH;
                end
            end
            ltpid_pkg::ST_SLEEP:
                pend_next = pop_tick.light ? ltpid_pkg::ST_SEARCH : ltpid_pkg::ST_SLEEP;
            ltpid_pkg::ST_TRACK:
                pend_next = !pop_tick.light ? ltpid_pkg::ST_SEARCH
                          : (pop_tick.aligned ? ltpid_pkg::ST_HOLD : ltpid_pkg::ST_TRACK);
            ltpid_pkg::ST_HOLD:
                pend_next = !pop_tick.light ? ltpid_pkg::ST_SEARCH
                          : (!pop_tick.aligned ? ltpid_pkg::ST_TRACK : ltpid_pkg::ST_HOLD);
            default:              pend_next = ltpid_pkg::ST_OFF;
        endcase
        if (!pop_tick.power)
        begin
            pend_next = ltpid_pkg::ST_OFF;
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        case (step_reg)
            SP_INTEG_X: begin mul_a = 18'({10'd0, cur_reg.dt}); mul_b = 24'(cur_reg.ex); end
            SP_INTEG_Y: begin mul_a = 18'({10'd0, cur_reg.dt}); mul_b = 24'(cur_reg.ey); end
            SP_DERIV_X:
            begin
                mul_a = 18'({8'd0, ltpid_pkg::MS_PER_S});
                mul_b = 24'(13'(cur_reg.ex) - 13'(pex_reg));
            end
            SP_DERIV_Y:
            begin
                mul_a = 18'({8'd0, ltpid_pkg::MS_PER_S});
                mul_b = 24'(13'(cur_reg.ey) - 13'(pey_reg));
            end
            SP_P_X: begin mul_a = $signed({2'b0, cfg.gain_p}); mul_b = 24'(cur_reg.ex); end
            SP_D_X: begin mul_a = $signed({2'b0, cfg.gain_d}); mul_b = deriv_x_reg; end
            SP_I_X: begin mul_a = $signed({2'b0, cfg.gain_i}); mul_b = 24'(integ_x_reg); end
            SP_P_Y: begin mul_a = $signed({2'b0, cfg.gain_p}); mul_b = 24'(cur_reg.ey); end
            SP_D_Y: begin mul_a = $signed({2'b0, cfg.gain_d}); mul_b = deriv_y_reg; end
            SP_I_Y: begin mul_a = $signed({2'b0, cfg.gain_i}); mul_b = 24'(integ_y_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Proportional and derivative terms carry an extra factor of 1024.
    always_comb
    begin
        if ((step_reg == SP_P_X) || (step_reg == SP_D_X)
            || (step_reg == SP_P_Y) || (step_reg == SP_D_Y))
        begin
            term = 52'(prod_reg) <<< 10;
        end
        else
        begin
            term = 52'(prod_reg);
        end
    end

    // Integral step: e*dt*1024/1000 by reciprocal multiplication on the magnitude.
    // Derivative step: de*1000/dt on the iterative divider.
    always_comb
    begin
        rcp_mag  = prod_reg[41] ? 20'(-prod_reg) : prod_reg[19:0];
        rcp_prod = 46'(rcp_mag) * 46'(ltpid_pkg::INTEG_RECIP);
        rcp_quot = rcp_neg_reg ? -$signed({1'b0, rcp_reg}) : $signed({1'b0, rcp_reg});

        div_dividend = 32'(prod_reg);
        div_divisor  = {2'b0, cur_reg.dt};
        div_start    = (phase_reg == PH_DST);

        integ_sel = (step_reg == SP_INTEG_X) ? integ_x_reg : integ_y_reg;
        integ_sum = 25'(integ_sel) + 25'(rcp_quot);
        if (integ_sum > 25'(ltpid_pkg::INTEG_LIMIT))
        begin
            integ_clamped = 23'(ltpid_pkg::INTEG_LIMIT);
        end
        else if (integ_sum < -25'(ltpid_pkg::INTEG_LIMIT))
        begin
            integ_clamped = -23'(ltpid_pkg::INTEG_LIMIT);
        end
        else
        begin
            integ_clamped = integ_sum[22:0];
        end
    end

    ltpid_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Floor of the Q22 sum, recentered and clamped to the servo limits.
    always_comb
    begin
        pid_q     = 30'(acc_reg >>> 22);
        pulse_raw = 31'(pid_q) + $signed({19'd0, ltpid_pkg::CENTER_US});
        pulse_lo  = $signed({19'd0, cfg.pulse_min_us});
        pulse_hi  = $signed({19'd0, cfg.pulse_max_us});
        if (pulse_raw < pulse_lo)
        begin
            pulse_val = cfg.pulse_min_us;
        end
        else if (pulse_raw > pulse_hi)
        begin
            pulse_val = cfg.pulse_max_us;
        end
        else
        begin
            pulse_val = pulse_raw[11:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_tick;
            pex_reg <= prev_ex_reg;
            pey_reg <= prev_ey_reg;
        end
        if (phase_reg == PH_MUL)
        begin
            prod_reg <= mul_p;
        end
        if (phase_reg == PH_RCP)
        begin
            rcp_reg     <= rcp_prod[ltpid_pkg::INTEG_RECIP_SHIFT +: 20];
            rcp_neg_reg <= prod_reg[41];
        end
        if (phase_reg == PH_ADD)
        begin
            acc_reg <= ((step_reg == SP_P_X) || (step_reg == SP_P_Y)) ? term : acc_reg + term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            step_reg      <= SP_INTEG_X;
            pend_reg      <= ltpid_pkg::ST_OFF;
            act_reg       <= ltpid_pkg::ST_OFF;
            timer_reg     <= '0;
            first_reg     <= 1'b1;
            prev_ex_reg   <= '0;
            prev_ey_reg   <= '0;
            integ_x_reg   <= '0;
            integ_y_reg   <= '0;
            deriv_x_reg   <= '0;
            deriv_y_reg   <= '0;
            pos_x_reg     <= ltpid_pkg::CENTER_US;
            pos_y_reg     <= ltpid_pkg::CENTER_US;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_state_reg <= ltpid_pkg::ST_OFF;
            out_x_reg     <= ltpid_pkg::CENTER_US;
            out_y_reg     <= ltpid_pkg::CENTER_US;
            out_upd_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (phase_reg)
                PH_IDLE:
                begin
                    if (pop_valid)
                    begin
                        timer_reg   <= timer_next;
                        first_reg   <= first_next;
                        act_reg     <= pend_reg;
                        pend_reg    <= pend_next;
                        prev_ex_reg <= pop_tick.ex;
                        prev_ey_reg <= pop_tick.ey;
                        upd_reg     <= 1'b0;
                        phase_reg   <= PH_DONE;
                        if (track_entry && (act_reg != ltpid_pkg::ST_HOLD))
                        begin
                            integ_x_reg <= '0;
                            integ_y_reg <= '0;
                        end
                        if (pop_tick.power && (pend_reg == ltpid_pkg::ST_INIT))
                        begin
                            pos_x_reg   <= ltpid_pkg::CENTER_US;
                            pos_y_reg   <= ltpid_pkg::CENTER_US;
                            integ_x_reg <= '0;
                            integ_y_reg <= '0;
                            deriv_x_reg <= '0;
                            deriv_y_reg <= '0;
                            upd_reg     <= 1'b1;
                        end
                        if (pop_tick.power && (pend_reg == ltpid_pkg::ST_TRACK))
                        begin
                            first_reg <= 1'b0;
                            upd_reg   <= 1'b1;
                            step_reg  <= first_next ? SP_P_X : SP_INTEG_X;
                            phase_reg <= PH_MUL;
                        end
                    end
                end
                PH_MUL:
                begin
                    if (step_reg < SP_DERIV_X)
                    begin
                        phase_reg <= PH_RCP;
                    end
                    else
                    begin
                        phase_reg <= (step_reg < SP_P_X) ? PH_DST : PH_ADD;
                    end
                end
                PH_RCP:
                begin
                    phase_reg <= PH_DIV;
                end
                PH_DST:
                begin
                    phase_reg <= PH_DIV;
                end
                PH_DIV:
                begin
                    // Integral steps arrive here with their increment already registered.
                    if (div_done || (step_reg < SP_DERIV_X))
                    begin
                        case (step_reg)
                            SP_INTEG_X: integ_x_reg <= integ_clamped;
                            SP_INTEG_Y: integ_y_reg <= integ_clamped;
                            SP_DERIV_X: deriv_x_reg <= 24'(div_quot);
                            default:    deriv_y_reg <= 24'(div_quot);
                        endcase
                        step_reg  <= step_reg + 1'b1;
                        phase_reg <= PH_MUL;
                    end
                end
                PH_ADD:
                begin
                    if ((step_reg == SP_I_X) || (step_reg == SP_I_Y))
                    begin
                        phase_reg <= PH_POS;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        phase_reg <= PH_MUL;
                    end
                end
                PH_POS:
                begin
                    if (step_reg == SP_I_Y)
                    begin
                        pos_y_reg <= pulse_val;
                        phase_reg <= PH_DONE;
                    end
                    else
                    begin
                        pos_x_reg <= pulse_val;
                        step_reg  <= SP_P_Y;
                        phase_reg <= PH_MUL;
                    end
                end
                PH_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_state_reg <= act_reg;
                        out_x_reg     <= pos_x_reg;
                        out_y_reg     <= pos_y_reg;
                        out_upd_reg   <= upd_reg;
                        phase_reg     <= PH_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.active_state = out_state_reg;
    assign result.pulse_x_us   = out_x_reg;
    assign result.pulse_y_us   = out_y_reg;
    assign result.pulse_update = out_upd_reg;

endmodule

### design/light_tracker_pid_controller_top.sv
// Light tracker PID controller, top level.
// Sample channel: one transaction per tick carries four light readings, the
// milliseconds since the previous tick and the power enable. Result channel:
// exactly one transaction per tick with the state acted on, both servo pulse
// widths and a flag that says whether the servos were written.
// Configuration: cfg_we, cfg_index and cfg_data write one register per edge;
// write only while no tick is in flight.
// Sequence: a tick that does not track passes through the done state straight
// to its result. A tracking tick runs two integral updates by reciprocal
// multiplication and two derivative divisions in the shared two-bit-per-cycle
// divider, then six multiply and accumulate steps and two position updates.
// The first tracking tick skips the integral and derivative updates. Ticks
// are worked one at a time.
// A small queue after the front end keeps accepting ticks while the back end
// works, and the result register lets the next tick run while a result waits.
// When the receiver stalls, the result holds and the queue fills, after which
// the sample channel drops ready.
// Reset puts the control registers, not datapath ones, at documented values:
// state off, servos at 1500 us, integrators and derivatives at zero.
module light_tracker_pid_controller_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ltpid_sample_if.sink                    sample,
    ltpid_result_if.source                  result,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [ltpid_pkg::CFG_DATA_W-1:0] cfg_data
);
    ltpid_pkg::cfg_t  cfg_reg;
    ltpid_pkg::tick_t push_tick, pop_tick;
    logic             push_valid, push_ready, pop_valid, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_threshold   <= 10'd35;
            cfg_reg.align_deadband    <= 11'd50;
            cfg_reg.search_timeout_ms <= 16'd5000;
            cfg_reg.gain_p            <= 16'd410;
            cfg_reg.gain_i            <= 16'd4096;
            cfg_reg.gain_d            <= 16'd45;
            cfg_reg.pulse_min_us      <= 12'd550;
            cfg_reg.pulse_max_us      <= 12'd2450;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ltpid_pkg::REG_LIGHT_THRESHOLD: cfg_reg.light_threshold   <= cfg_data[9:0];
                ltpid_pkg::REG_ALIGN_DEADBAND:  cfg_reg.align_deadband    <= cfg_data[10:0];
                ltpid_pkg::REG_SEARCH_TIMEOUT:  cfg_reg.search_timeout_ms <= cfg_data;
                ltpid_pkg::REG_GAIN_P:          cfg_reg.gain_p            <= cfg_data;
                ltpid_pkg::REG_GAIN_I:          cfg_reg.gain_i            <= cfg_data;
                ltpid_pkg::REG_GAIN_D:          cfg_reg.gain_d            <= cfg_data;
                ltpid_pkg::REG_PULSE_MIN:       cfg_reg.pulse_min_us      <= cfg_data[11:0];
                ltpid_pkg::REG_PULSE_MAX:       cfg_reg.pulse_max_us      <= cfg_data[11:0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    ltpid_front u_front (
        .sample     (sample),
        .cfg        (cfg_reg),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_tick  (push_tick)
    );

    ltpid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tick  (push_tick),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_tick   (pop_tick)
    );

    ltpid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_tick  (pop_tick),
        .pop       (pop),
        .result    (result)
    );

endmodule

### design/ltpid_checker.sv
// Port-level checks on the result channel of the light tracker controller.
// Depends on ltpid_pkg; bound to light_tracker_pid_controller_top below.
module ltpid_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [2:0]  active_state,
    input logic [11:0] pulse_x_us,
    input logic [11:0] pulse_y_us,
    input logic        pulse_update
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(active_state) && $stable(pulse_x_us)
                            && $stable(pulse_y_us) && $stable(pulse_update))
        else $error("result changed while stalled");

    a_update_state: assert property (@(posedge clk) disable iff (!rst_n)
        valid && pulse_update |->
            (active_state == ltpid_pkg::ST_INIT) || (active_state == ltpid_pkg::ST_TRACK))
        else $error("servo update outside init or track");

    a_init_center: assert property (@(posedge clk) disable iff (!rst_n)
        valid && pulse_update && (active_state == ltpid_pkg::ST_INIT) |->
            (pulse_x_us == ltpid_pkg::CENTER_US) && (pulse_y_us == ltpid_pkg::CENTER_US))
        else $error("init did not center the servos");

    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (active_state <= ltpid_pkg::ST_HOLD))
        else $error("result carries an undefined state code");

endmodule

bind light_tracker_pid_controller_top ltpid_checker u_ltpid_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (result.valid),
    .ready        (result.ready),
    .active_state (result.active_state),
    .pulse_x_us   (result.pulse_x_us),
    .pulse_y_us   (result.pulse_y_us),
    .pulse_update (result.pulse_update)
);

### verif/tb_top.sv
// Testbench for the light tracker PID controller: directed and random sample
// ticks, with a tick-by-tick tracker predictor checking every result.
// Depends on ltpid_pkg, the channel interfaces and the design top level.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [2:0]  active_state;
        logic [11:0] pulse_x_us;
        logic [11:0] pulse_y_us;
        logic        pulse_update;
    } tracker_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [ltpid_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    ltpid_sample_if sample ();
    ltpid_result_if result ();

    light_tracker_pid_controller_top u_top (
        .clk(clk), .rst_n(rst_n), .sample(sample.sink), .result(result.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor copy of the registers and state.
    ltpid_pkg::cfg_t cfg;
    logic [2:0]  pend_st, act_st;
    int          srch_ms;
    bit          first_trk;
    int          prev_ex, prev_ey, integ_x, integ_y, deriv_x, deriv_y, pos_x, pos_y;

    tracker_out_t expected_q[$];
    int  n_errors = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    bit  rx_stall_on = 1'b1;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic int clamp_pulse(input longint v);
        if (v < longint'(cfg.pulse_min_us)) return cfg.pulse_min_us;
        if (v > longint'(cfg.pulse_max_us)) return cfg.pulse_max_us;
        return int'(v);
    endfunction

    task automatic pid_axis(input int e, input int pe, input int dt, inout int integ,
                            inout int deriv, output int pos);
        longint acc, sum, q;
        if (!first_trk)
        begin
            acc = longint'(integ) + (longint'(e) * dt * 1024) / 1000;
            if (acc > ltpid_pkg::INTEG_LIMIT) acc = ltpid_pkg::INTEG_LIMIT;
            if (acc < -ltpid_pkg::INTEG_LIMIT) acc = -ltpid_pkg::INTEG_LIMIT;
            integ = int'(acc);
            deriv = int'((longint'(e - pe) * 1000) / dt);
        end
        sum = longint'(cfg.gain_p) * e * 1024 + longint'(cfg.gain_d) * deriv * 1024
            + longint'(cfg.gain_i) * integ;
        q = sum / 4194304;
        if (sum % 4194304 != 0 && sum < 0) q--;
        pos = clamp_pulse(1500 + q);
    endtask

    task automatic predict_tick(input logic [9:0] tl, tr, ll, lr, input logic [7:0] ems,
                                input logic pwr);
        int ex, ey, pex, pey, dt;
        bit light, aligned, upd;
        tracker_out_t r;
        dt = (ems == 0) ? 1 : ems;
        upd = 0;
        ex = int'(tr) + int'(lr) - int'(tl) - int'(ll);
        ey = int'(tl) + int'(tr) - int'(ll) - int'(lr);
        pex = prev_ex; pey = prev_ey;
        prev_ex = ex; prev_ey = ey;
        light = tl > cfg.light_threshold || tr > cfg.light_threshold ||
                ll > cfg.light_threshold || lr > cfg.light_threshold;
        aligned = (ex < 0 ? -ex : ex) <= cfg.align_deadband &&
                  (ey < 0 ? -ey : ey) <= cfg.align_deadband;
        if (pend_st == ltpid_pkg::ST_SEARCH && act_st != ltpid_pkg::ST_SEARCH) srch_ms = 0;
        else
        begin
            srch_ms += dt;
            if (srch_ms > ltpid_pkg::TIMER_MAX) srch_ms = ltpid_pkg::TIMER_MAX;
        end
        if (pend_st == ltpid_pkg::ST_TRACK && act_st != ltpid_pkg::ST_TRACK)
        begin
            first_trk = 1;
            if (act_st != ltpid_pkg::ST_HOLD)
            begin
                integ_x = 0; integ_y = 0;
            end
        end
        act_st = pend_st;
        if (!pwr) pend_st = ltpid_pkg::ST_OFF;
        else
        begin
            case (act_st)
                ltpid_pkg::ST_OFF: pend_st = ltpid_pkg::ST_INIT;
                ltpid_pkg::ST_INIT:
                begin
                    pos_x = 1500; pos_y = 1500;
                    integ_x = 0; integ_y = 0; deriv_x = 0; deriv_y = 0;
                    upd = 1;
                    pend_st = ltpid_pkg::ST_SEARCH;
                end
                ltpid_pkg::ST_SEARCH:
                    pend_st = light ? ltpid_pkg::ST_TRACK :
                              (srch_ms > cfg.search_timeout_ms ? ltpid_pkg::ST_SLEEP
                                                               : ltpid_pkg::ST_SEARCH);
                ltpid_pkg::ST_SLEEP:
                    pend_st = light ? ltpid_pkg::ST_SEARCH : ltpid_pkg::ST_SLEEP;
                ltpid_pkg::ST_TRACK:
                begin
                    pend_st = !light ? ltpid_pkg::ST_SEARCH
                            : (aligned ? ltpid_pkg::ST_HOLD : ltpid_pkg::ST_TRACK);
                    pid_axis(ex, pex, dt, integ_x, deriv_x, pos_x);
                    pid_axis(ey, pey, dt, integ_y, deriv_y, pos_y);
                    first_trk = 0;
                    upd = 1;
                end
                ltpid_pkg::ST_HOLD:
                    pend_st = !light ? ltpid_pkg::ST_SEARCH
                            : (!aligned ? ltpid_pkg::ST_TRACK : ltpid_pkg::ST_HOLD);
                default: pend_st = ltpid_pkg::ST_OFF;
            endcase
        end
        r.active_state = act_st;
        r.pulse_x_us = pos_x[11:0];
        r.pulse_y_us = pos_y[11:0];
        r.pulse_update = upd;
        expected_q.push_back(r);
    endtask

    task automatic send_tick(input int tl, tr, ll, lr, ems, input bit pwr);
        logic [9:0] tl_v, tr_v, ll_v, lr_v;
        logic [7:0] ems_v;
        tl_v = 10'(tl); tr_v = 10'(tr);
        ll_v = 10'(ll); lr_v = 10'(lr);
        ems_v = 8'(ems);
        sample.valid <= 1'b1;
        sample.top_left <= tl_v; sample.top_right <= tr_v;
        sample.low_left <= ll_v; sample.low_right <= lr_v;
        sample.elapsed_ms <= ems_v; sample.power_on <= pwr;
        @(posedge clk);
        while (!sample.ready) @(posedge clk);
        predict_tick(tl_v, tr_v, ll_v, lr_v, ems_v, pwr);
    endtask

    // Random gap after a transaction; mostly none, a few long ones.
    task automatic tx_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 60) return;
        sample.valid <= 1'b0;
        repeat (n < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ltpid_pkg::REG_LIGHT_THRESHOLD: cfg.light_threshold = val[9:0];
            ltpid_pkg::REG_ALIGN_DEADBAND:  cfg.align_deadband = val[10:0];
            ltpid_pkg::REG_SEARCH_TIMEOUT:  cfg.search_timeout_ms = val[15:0];
            ltpid_pkg::REG_GAIN_P:          cfg.gain_p = val[15:0];
            ltpid_pkg::REG_GAIN_I:          cfg.gain_i = val[15:0];
            ltpid_pkg::REG_GAIN_D:          cfg.gain_d = val[15:0];
            ltpid_pkg::REG_PULSE_MIN:       cfg.pulse_min_us = val[11:0];
            default:                        cfg.pulse_max_us = val[11:0];
        endcase
    endtask

    task automatic write_all(input int thr, db, tmo, gp, gi, gd, pmin, pmax);
        write_reg(ltpid_pkg::REG_LIGHT_THRESHOLD, thr);
        write_reg(ltpid_pkg::REG_ALIGN_DEADBAND, db);
        write_reg(ltpid_pkg::REG_SEARCH_TIMEOUT, tmo);
        write_reg(ltpid_pkg::REG_GAIN_P, gp);
        write_reg(ltpid_pkg::REG_GAIN_I, gi);
        write_reg(ltpid_pkg::REG_GAIN_D, gd);
        write_reg(ltpid_pkg::REG_PULSE_MIN, pmin);
        write_reg(ltpid_pkg::REG_PULSE_MAX, pmax);
    endtask

    // Bright source offset by a random amount so tracking has real errors.
    task automatic send_bright(input int spread);
        int b;
        b = $urandom_range(200, 1023 - spread);
        send_tick(b + $urandom_range(0, spread), b + $urandom_range(0, spread),
                  b + $urandom_range(0, spread), b + $urandom_range(0, spread),
                  $urandom_range(0, 40), 1'b1);
    endtask

    task automatic test_directed();
        send_tick(0, 0, 0, 0, 0, 1'b1);                 // off -> init
        send_tick(0, 0, 0, 0, 20, 1'b1);                // init writes center
        send_tick(1023, 1023, 1023, 1023, 255, 1'b1);   // search sees light
        send_tick(1023, 0, 1023, 0, 0, 1'b1);           // first track, stale derivative
        send_tick(0, 1023, 0, 1023, 1, 1'b1);           // full swing errors
        send_tick(1023, 1023, 0, 0, 255, 1'b1);
        send_tick(0, 0, 1023, 1023, 20, 1'b1);
        send_tick(500, 500, 500, 500, 20, 1'b1);        // aligned -> hold
        send_tick(500, 500, 500, 500, 20, 1'b1);        // hold stays
        send_tick(900, 100, 900, 100, 20, 1'b1);        // hold -> track, integ kept
        send_tick(900, 100, 900, 100, 20, 1'b1);
        send_tick(0, 0, 0, 0, 20, 1'b1);                // no light -> search
        repeat (3) send_tick(10, 20, 30, 35, 255, 1'b1); // search stays, below the timeout
        send_tick(36, 0, 0, 0, 20, 1'b1);               // search sees light
        send_tick(0, 0, 0, 0, 20, 1'b0);                // power off
        send_tick(1023, 1023, 1023, 1023, 20, 1'b1);
        drain();
    endtask

    task automatic test_limits();
        // Extremes: inverted servo limits, zero and full gains, zero threshold.
        write_all(0, 0, 0, 65535, 65535, 65535, 4095, 0);
        repeat (3) send_tick(0, 0, 0, 0, 10, 1'b1);
        repeat (12) send_bright(823);
        drain();
        write_all(1023, 2047, 65535, 0, 0, 0, 0, 4095);
        repeat (10) send_tick(1023, $urandom_range(0, 1023), 1023, 0, 255, 1'b1);
        repeat (600) send_tick(0, 0, 0, 0, 255, 1'b1);  // reach timer saturation
        drain();
    endtask

    task automatic test_random(input int n_items);
        int k;
        for (int i = 0; i < n_items; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 70) send_bright($urandom_range(0, 800));
            else if (k < 85) send_tick($urandom_range(0, 60), $urandom_range(0, 60),
                                       $urandom_range(0, 60), $urandom_range(0, 60),
                                       $urandom_range(0, 255), 1'b1);
            else if (k < 97) send_tick($urandom_range(0, 1023), $urandom_range(0, 1023),
                                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                                       $urandom_range(0, 255), 1'b1);
            else send_tick($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
            if (i % 200 < 150) tx_gap();
        end
        drain();
    endtask

    task automatic test_backpressure();
        // Receiver holds off for a fixed stretch while ticks keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        repeat (12) send_bright(600);
        wait (hold_off == 1'b0);
        drain();
    endtask

    // Result side: random stalls, long hold-off on request.
    always @(posedge clk)
    begin
        int n;
        n = $urandom_range(0, 99);
        if (hold_off) result.ready <= 1'b0;
        else if (!rx_stall_on) result.ready <= 1'b1;
        else result.ready <= (n < 70) || (n >= 98 && $urandom_range(0, 1) == 1);
    end

    always @(posedge clk)
    begin
        tracker_out_t w;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_q.size() == 0) report("unexpected result", 0, 0);
            else
            begin
                w = expected_q.pop_front();
                if (result.active_state !== w.active_state)
                    report("active_state", result.active_state, w.active_state);
                if (result.pulse_x_us !== w.pulse_x_us)
                    report("pulse_x_us", result.pulse_x_us, w.pulse_x_us);
                if (result.pulse_y_us !== w.pulse_y_us)
                    report("pulse_y_us", result.pulse_y_us, w.pulse_y_us);
                if (result.pulse_update !== w.pulse_update)
                    report("pulse_update", result.pulse_update, w.pulse_update);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready) || cfg_we)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        sample.valid = 1'b0;
        sample.top_left = '0; sample.top_right = '0;
        sample.low_left = '0; sample.low_right = '0;
        sample.elapsed_ms = '0; sample.power_on = 1'b0;
        result.ready = 1'b0;
        cfg = '{10'd35, 11'd50, 16'd5000, 16'd410, 16'd4096, 16'd45, 12'd550, 12'd2450};
        pend_st = ltpid_pkg::ST_OFF; act_st = ltpid_pkg::ST_OFF; srch_ms = 0; first_trk = 1;
        prev_ex = 0; prev_ey = 0; integ_x = 0; integ_y = 0;
        deriv_x = 0; deriv_y = 0; pos_x = 1500; pos_y = 1500;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        rx_stall_on = 1'b0;
        test_directed();
        rx_stall_on = 1'b1;
        test_limits();
        write_all(35, 50, 300, 410, 4096, 45, 550, 2450);
        test_backpressure();
        test_random(550);
        write_all($urandom_range(0, 1023), $urandom_range(0, 400), $urandom_range(0, 2000),
                  $urandom, $urandom, $urandom, $urandom_range(0, 1500),
                  $urandom_range(1500, 4095));
        test_random(550);
        if (n_errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
